@@ rtl/binary_tree_backward_reduction_core_macros.svh @@
// Assertion macros used by the checker file of the tree reduction core.
`ifndef BINARY_TREE_BACKWARD_REDUCTION_CORE_MACROS_SVH
`define BINARY_TREE_BACKWARD_REDUCTION_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BTBR_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BTBR_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

@@ rtl/btbr_pkg.sv @@
// Package with the constants and register codes of the tree reduction core.
package btbr_pkg;

  // Default tree size and fixed field widths.
  localparam int MAX_DEPTH_DEF = 10;
  localparam int VALUE_W       = 32;
  localparam int WEIGHT_FRAC   = 16;
  localparam int WEIGHT_W      = WEIGHT_FRAC + 1;
  localparam int STRIKE_W      = 31;
  localparam int DEPTH_CFG_W   = 4;

  // Configuration port geometry.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 2;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_TREE_DEPTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_STRIKE       = 2'd1;
  localparam logic [IDX_W-1:0] REG_UP_WEIGHT    = 2'd2;
  localparam logic [IDX_W-1:0] REG_APPLY_PAYOFF = 2'd3;

  // Register reset values.
  localparam logic [DEPTH_CFG_W-1:0] RST_TREE_DEPTH = 4'd1;
  localparam logic [STRIKE_W-1:0]    RST_STRIKE     = '0;
  localparam logic [WEIGHT_W-1:0]    RST_UP_WEIGHT  = 17'd32768;

  // Weight of one in Q1.16.
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

endpackage

@@ rtl/binary_tree_backward_reduction_core.sv @@
// Top level of the binary tree backward reduction core.
//
//  channel   | ports                                | handshake
//  ----------+--------------------------------------+------------------------------
//  leaf in   | start, busy, in_leaf_value           | beat when start & !busy
//  root out  | out_valid, out_root_value            | one-cycle strobe, no stall
//  config    | psel, penable, pwrite, paddr, pwdata | APB write, pready always high
//
// A leaf that does not complete the tree leaves busy low.
// The completing leaf starts the reduction: busy stays high while pairs are read,
// one pair per cycle from the dual-read node memory except where each level waits
// to drain the three-stage read, multiply, write-back pipeline before the next level.
// The root beat is strobed in the first cycle busy is low again.
// Reset (rst_n, synchronous) clears the leaf count, the sequencer and the configuration registers;
// the node memory holds no reset value. The receiver cannot stall the result.
module binary_tree_backward_reduction_core
  import btbr_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Leaf input.
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] in_leaf_value,
  // Root output.
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_root_value,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  localparam int AW    = MAX_DEPTH;
  localparam int DEPTH = 1 << MAX_DEPTH;
  localparam int CNT_W = MAX_DEPTH + 1;
  localparam int LW    = $clog2(MAX_DEPTH + 1);
  localparam int CW    = (LW > DEPTH_CFG_W) ? LW : DEPTH_CFG_W;
  localparam int PW    = WEIGHT_W + 1 + VALUE_W;
  localparam int SW    = VALUE_W + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RED  = 1'b1;

  typedef struct packed {
    logic          vld;
    logic          last;
    logic [AW-1:0] addr;
  } stage_t;

  // Configuration registers.
  logic [DEPTH_CFG_W-1:0] depth_r;
  logic [STRIKE_W-1:0]    strike_r;
  logic [WEIGHT_W-1:0]    upw_r;
  logic                   payoff_r;

  // Control state.
  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0]    lvl_r, lvl_nxt;
  logic [AW-1:0]    j_r, j_nxt;
  logic             wait_r, wait_nxt;
  logic             out_valid_r, out_valid_nxt;
  stage_t           s1_r, s1_nxt, s2_r;

  // Payload registers.
  logic [WEIGHT_W-1:0]       w_r;
  logic signed [VALUE_W-1:0] rd_l_r, rd_r_r;
  logic signed [PW-1:0]      prod_l_r, prod_r_r;
  logic signed [VALUE_W-1:0] out_root_r;

  // Node memory.
  logic [VALUE_W-1:0] mem [DEPTH];

  logic                      cfg_wr;
  logic [IDX_W-1:0]          cfg_idx;
  logic                      acc;
  logic [CW-1:0]             depth_ext;
  logic [LW-1:0]             dep_eff;
  logic [CNT_W-1:0]          leaves;
  logic                      tree_done;
  logic [WEIGHT_W-1:0]       w_clamp;
  logic signed [VALUE_W:0]   diff;
  logic [VALUE_W-1:0]        leaf_wr;
  logic                      issue;
  logic [AW-1:0]             half_m1;
  logic [AW-1:0]             addr_l, addr_r;
  logic signed [SW-1:0]      sh_l, sh_r;
  logic signed [SW:0]        sum;
  logic [VALUE_W-1:0]        node_val;
  logic                      mem_we;
  logic [AW-1:0]             mem_wa;
  logic [VALUE_W-1:0]        mem_wd;

  // Configuration port decode.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[IDX_W+1:2];

  always_comb begin
    unique case (cfg_idx)
      REG_TREE_DEPTH:   prdata = DATA_W'(depth_r);
      REG_STRIKE:       prdata = DATA_W'(strike_r);
      REG_UP_WEIGHT:    prdata = DATA_W'(upw_r);
      REG_APPLY_PAYOFF: prdata = DATA_W'(payoff_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= RST_TREE_DEPTH;
      strike_r <= RST_STRIKE;
      upw_r    <= RST_UP_WEIGHT;
      payoff_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TREE_DEPTH:   depth_r  <= pwdata[DEPTH_CFG_W-1:0];
        REG_STRIKE:       strike_r <= pwdata[STRIKE_W-1:0];
        REG_UP_WEIGHT:    upw_r    <= pwdata[WEIGHT_W-1:0];
        REG_APPLY_PAYOFF: payoff_r <= pwdata[0];
        default:          ;
      endcase
    end
  end

  // Effective depth, clamped to one through MAX_DEPTH, and the leaf count it implies.
  assign depth_ext = CW'(depth_r);
  always_comb begin
    if (depth_ext == '0) begin
      dep_eff = LW'(1);
    end else if (depth_ext > CW'(MAX_DEPTH)) begin
      dep_eff = LW'(MAX_DEPTH);
    end else begin
      dep_eff = LW'(depth_ext);
    end
  end
  assign leaves = CNT_W'(1) << dep_eff;

  // Leaf intake with optional call payoff taken at full width.
  assign busy      = (state_r == ST_RED);
  assign acc       = start && !busy;
  assign cnt_nxt   = cnt_r + CNT_W'(1);
  assign tree_done = (cnt_nxt >= leaves) || (cnt_nxt == '0);
  assign w_clamp   = (upw_r > WEIGHT_ONE) ? WEIGHT_ONE : upw_r;
  assign diff      = $signed({in_leaf_value[VALUE_W-1], in_leaf_value})
                   - $signed({2'b00, strike_r});
  always_comb begin
    if (!payoff_r) begin
      leaf_wr = in_leaf_value;
    end else if (diff[VALUE_W]) begin
      leaf_wr = '0;
    end else begin
      leaf_wr = diff[VALUE_W-1:0];
    end
  end

  // Pair issue: one pair a cycle, waiting at a level start until the writes drain.
  assign half_m1 = (AW'(1) << (lvl_r - LW'(1))) - AW'(1);
  assign addr_l  = AW'({j_r, 1'b0});
  assign addr_r  = addr_l | AW'(1);
  assign issue   = (state_r == ST_RED) && (lvl_r != '0)
                && (!wait_r || (!s1_r.vld && !s2_r.vld));

  always_comb begin
    s1_nxt.vld  = issue;
    s1_nxt.last = (lvl_r == LW'(1));
    s1_nxt.addr = j_r;
  end

  // Weighted sum with floor division, then saturation to the value range.
  assign sh_l = SW'(prod_l_r >>> WEIGHT_FRAC);
  assign sh_r = SW'(prod_r_r >>> WEIGHT_FRAC);
  assign sum  = {sh_l[SW-1], sh_l} + {sh_r[SW-1], sh_r};
  always_comb begin
    if (sum[SW:VALUE_W-1] == '0 || sum[SW:VALUE_W-1] == '1) begin
      node_val = sum[VALUE_W-1:0];
    end else if (sum[SW]) begin
      node_val = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      node_val = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    j_nxt         = j_r;
    wait_nxt      = wait_r;
    out_valid_nxt = 1'b0;
    if (issue) begin
      if (j_r == half_m1) begin
        j_nxt    = '0;
        lvl_nxt  = lvl_r - LW'(1);
        wait_nxt = 1'b1;
      end else begin
        j_nxt    = j_r + AW'(1);
        wait_nxt = 1'b0;
      end
    end
    if (s2_r.vld && s2_r.last) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
    end
    if (acc && tree_done) begin
      state_nxt = ST_RED;
      lvl_nxt   = dep_eff;
      j_nxt     = '0;
      wait_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      lvl_r       <= '0;
      j_r         <= '0;
      wait_r      <= 1'b1;
      out_valid_r <= 1'b0;
      s1_r        <= '0;
      s2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      j_r         <= j_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s1_r;
      if (acc) begin
        cnt_r <= tree_done ? '0 : cnt_nxt;
      end
    end
  end

  // Weight latch, products and result register.
  always_ff @(posedge clk) begin
    if (acc && tree_done) begin
      w_r <= w_clamp;
    end
    prod_l_r <= $signed({1'b0, w_r}) * rd_l_r;
    prod_r_r <= $signed({1'b0, WEIGHT_ONE - w_r}) * rd_r_r;
    if (s2_r.vld && s2_r.last) begin
      out_root_r <= node_val;
    end
  end

  // Node memory: one write port shared by leaf loads and write-back, two read ports.
  assign mem_we = (acc) || s2_r.vld;
  assign mem_wa = s2_r.vld ? s2_r.addr : cnt_r[AW-1:0];
  assign mem_wd = s2_r.vld ? node_val : leaf_wr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_l_r <= mem[addr_l];
    rd_r_r <= mem[addr_r];
  end

  assign out_valid      = out_valid_r;
  assign out_root_value = out_root_r;

endmodule

@@ rtl/btbr_checker.sv @@
// Port-level checker for the tree reduction core and its bind statement.
`include "binary_tree_backward_reduction_core_macros.svh"

module btbr_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A root beat is never strobed in back-to-back cycles.
  `BTBR_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "root strobed twice in a row")

  // A root beat only follows a reduction.
  `BTBR_ASSERT_NOW(a_strobe_after_busy, out_valid, $past(busy), "root without reduction")

  // The end of a reduction always delivers the root.
  `BTBR_ASSERT_NOW(a_busy_end_strobe, $fell(busy) && $past(rst_n), out_valid,
    "reduction ended without a root beat")

  // A reduction only starts from an accepted leaf beat.
  `BTBR_ASSERT_NOW(a_busy_from_leaf, $rose(busy), $past(start), "reduction without leaf beat")

endmodule

bind binary_tree_backward_reduction_core btbr_checker u_btbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
